[hw/rtl/tlfq_pkg.sv]
// ----------------------------------------------------------------------------
// tlfq_pkg
// Shared types and constants of the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfq_pkg;

  localparam int unsigned DEF_TASK_SLOTS = 64;

  localparam logic [3:0] RUNTIME_MAX = 4'd15;
  localparam logic [3:0] L0_LIMIT    = 4'd4;
  localparam logic [3:0] L1_LIMIT    = 4'd6;
  localparam logic [3:0] L2_LIMIT    = 4'd8;
  localparam logic [1:0] TOP_PRIO    = 2'd3;

  localparam int unsigned APB_AW       = 3;
  localparam logic [2:0]  ADDR_LOCK_KEY = 3'd0;

  typedef enum logic [2:0] {
    ACT_ADMIT    = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_PICK     = 3'd2,
    ACT_YIELD    = 3'd3,
    ACT_BOOST    = 3'd4,
    ACT_LOCK     = 3'd5,
    ACT_UNLOCK   = 3'd6,
    ACT_SET_PRIO = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_NONE        = 3'd1,
    STAT_ALREADY     = 3'd2,
    STAT_NOT_LOCKED  = 3'd3,
    STAT_WRONG_KEY   = 3'd4,
    STAT_INVALID     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_LOOK,
    ST_LOOK_WAIT,
    ST_UNLINK,
    ST_FRONT,
    ST_BOOST,
    ST_APPLY,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  slot;
    logic [30:0] task_id;
    logic [1:0]  new_priority;
    logic [31:0] key;
  } sched_in_t;

  typedef struct packed {
    logic       granted;
    logic [5:0] chosen_slot;
    logic [1:0] chosen_level;
    logic [2:0] status;
    logic       locked;
  } sched_out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic find;
    logic look;
    logic look_cap;
    logic unlink;
    logic front;
    logic boost;
    logic apply;
    logic push;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_e act;
    logic    err;
    logic    locked;
    logic    tgt_queued;
    logic    scan_done;
    logic    out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/tlfq_ctrl.sv]
// ----------------------------------------------------------------------------
// tlfq_ctrl
// Sequencer: walks each transaction through decode, sweeps and update.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfq_ctrl import tlfq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat_i.err) begin
          state_d = ST_DONE;
        end else if (stat_i.act == ACT_BOOST) begin
          state_d = ST_BOOST;
        end else if (stat_i.act == ACT_PICK && !stat_i.locked) begin
          state_d = ST_FIND;
        end else if (stat_i.act == ACT_ADMIT) begin
          state_d = ST_APPLY;
        end else begin
          state_d = ST_LOOK;
        end
      end
      ST_FIND: begin
        if (stat_i.scan_done) state_d = ST_LOOK;
      end
      ST_LOOK: state_d = ST_LOOK_WAIT;
      ST_LOOK_WAIT: begin
        if (stat_i.tgt_queued && (stat_i.act == ACT_REMOVE || stat_i.act == ACT_PICK ||
                                  stat_i.act == ACT_UNLOCK)) begin
          state_d = ST_UNLINK;
        end else if (stat_i.act == ACT_UNLOCK) begin
          state_d = ST_FRONT;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_UNLINK: begin
        if (stat_i.scan_done) state_d = (stat_i.act == ACT_UNLOCK) ? ST_FRONT : ST_APPLY;
      end
      ST_FRONT: begin
        if (stat_i.scan_done) state_d = ST_APPLY;
      end
      ST_BOOST: begin
        if (stat_i.scan_done) state_d = ST_APPLY;
      end
      ST_APPLY: state_d = ST_DONE;
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DECODE:    cmd_o.decode   = 1'b1;
      ST_FIND:      cmd_o.find     = 1'b1;
      ST_LOOK:      cmd_o.look     = 1'b1;
      ST_LOOK_WAIT: cmd_o.look_cap = 1'b1;
      ST_UNLINK:    cmd_o.unlink   = 1'b1;
      ST_FRONT:     cmd_o.front    = 1'b1;
      ST_BOOST:     cmd_o.boost    = 1'b1;
      ST_APPLY:     cmd_o.apply    = 1'b1;
      ST_DONE:      cmd_o.push     = stat_i.out_free;
      default:      cmd_o          = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tlfq_dp.sv]
// ----------------------------------------------------------------------------
// tlfq_dp
// Datapath: task table memory, queue bookkeeping, sweep engine, result.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfq_dp import tlfq_pkg::*; #(
  parameter int unsigned TaskSlots = DEF_TASK_SLOTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire sched_in_t   in_data_i,
  input  wire logic [31:0] lock_key_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output sched_out_t       out_data_o
);

  localparam int unsigned IW = $clog2(TaskSlots);
  localparam int unsigned CW = $clog2(TaskSlots + 1);
  localparam int unsigned XW = ((IW > 6) ? IW : 6) + 1;

  typedef struct packed {
    logic [1:0]    lv;
    logic [1:0]    prio;
    logic [3:0]    rt;
    logic [30:0]   pid;
    logic [IW-1:0] pos;   // place within its level, head is zero
  } ent_t;

  ent_t mem_q [TaskSlots];
  ent_t rdata_q, ent_q, wdata;
  logic          we;
  logic [IW-1:0] waddr, raddr;

  sched_in_t     req_q;
  action_e       act;
  logic [TaskSlots-1:0] queued_q;
  logic [CW-1:0] cnt0_q, cnt1_q, cnt2_q;
  logic          run_vld_q, lock_q, best_vld_q, out_vld_q;
  logic [IW-1:0] run_q, holder_q, target_q, best_q, best_pos_q;
  logic [1:0]    find_lv_q, best_prio_q;
  logic [30:0]   best_pid_q;
  logic [CW-1:0] scan_q;
  sched_out_t    res_q, out_q, res_d;

  assign act = action_e'(req_q.action);

  // Slot checks
  logic [XW-1:0] slot_x;
  logic [IW-1:0] slot_idx;
  logic          in_range, used_slot;
  logic [2:0]    err_code;

  assign slot_x    = XW'(req_q.slot);
  assign in_range  = slot_x < XW'(TaskSlots);
  assign slot_idx  = IW'(req_q.slot);
  assign used_slot = in_range && (queued_q[slot_idx] || (run_vld_q && run_q == slot_idx) ||
                                  (lock_q && holder_q == slot_idx));

  always_comb begin
    err_code = STAT_OK;
    case (act)
      ACT_ADMIT:    if (!in_range || used_slot) err_code = STAT_INVALID;
      ACT_REMOVE,
      ACT_SET_PRIO: if (!used_slot) err_code = STAT_INVALID;
      ACT_PICK: begin
        if (run_vld_q) err_code = STAT_INVALID;
        else if (!lock_q && cnt0_q == '0 && cnt1_q == '0 && cnt2_q == '0)
          err_code = STAT_NONE;
      end
      ACT_YIELD:    if (!run_vld_q) err_code = STAT_INVALID;
      ACT_LOCK: begin
        if (lock_q) err_code = STAT_ALREADY;
        else if (!run_vld_q) err_code = STAT_INVALID;
        else if (req_q.key != lock_key_i) err_code = STAT_WRONG_KEY;
      end
      ACT_UNLOCK: begin
        if (!lock_q) err_code = STAT_NOT_LOCKED;
        else if (req_q.key != lock_key_i) err_code = STAT_WRONG_KEY;
      end
      default: err_code = STAT_OK;
    endcase
  end

  // Sweep engine: read slot k while working on slot k-1, whose read is registered
  logic          scan, elem_vld, q_e, used_e, better, take, done;
  logic [IW-1:0] e;
  logic [CW-1:0] boost_off;

  assign scan     = cmd_i.find | cmd_i.unlink | cmd_i.front | cmd_i.boost;
  assign done     = scan && (scan_q == CW'(TaskSlots));
  assign elem_vld = scan && (scan_q != '0);
  assign e        = IW'(scan_q - 1'b1);
  assign q_e      = queued_q[e];
  assign used_e   = q_e || (run_vld_q && run_q == e) || (lock_q && holder_q == e);
  assign raddr    = scan ? scan_q[IW-1:0] : target_q;

  always_comb begin
    if (find_lv_q != 2'd2) begin
      better = rdata_q.pos == '0;
    end else begin
      better = !best_vld_q || rdata_q.prio < best_prio_q ||
               (rdata_q.prio == best_prio_q && (rdata_q.pid < best_pid_q ||
               (rdata_q.pid == best_pid_q && rdata_q.pos < best_pos_q)));
    end
  end

  // Candidate seen this cycle replaces the best so far
  assign take = cmd_i.find && elem_vld && q_e && rdata_q.lv == find_lv_q && better;

  assign boost_off = (rdata_q.lv == 2'd1) ? cnt0_q :
                     (rdata_q.lv == 2'd2) ? CW'(cnt0_q + cnt1_q) : '0;

  // Requeue after a tick
  logic [3:0]    rt1, y_rt;
  logic [1:0]    y_lv, y_prio;
  logic [CW-1:0] y_cnt;

  always_comb begin
    rt1    = (ent_q.rt == RUNTIME_MAX) ? RUNTIME_MAX : ent_q.rt + 4'd1;
    y_lv   = ent_q.lv;
    y_rt   = rt1;
    y_prio = ent_q.prio;
    if (ent_q.lv == 2'd0 && rt1 >= L0_LIMIT) begin
      y_lv = 2'd1;
      y_rt = '0;
    end else if (ent_q.lv == 2'd1 && rt1 >= L1_LIMIT) begin
      y_lv = 2'd2;
      y_rt = '0;
    end else if (ent_q.lv == 2'd2 && rt1 >= L2_LIMIT) begin
      if (ent_q.prio != 2'd0) y_prio = ent_q.prio - 2'd1;
      y_rt = '0;
    end
    y_cnt = (y_lv == 2'd0) ? cnt0_q : (y_lv == 2'd1) ? cnt1_q : cnt2_q;
  end

  // Memory write port
  always_comb begin
    we    = 1'b0;
    waddr = e;
    wdata = rdata_q;
    if (cmd_i.unlink) begin
      we = elem_vld && q_e && rdata_q.lv == ent_q.lv && rdata_q.pos > ent_q.pos;
      wdata.pos = rdata_q.pos - 1'b1;
    end else if (cmd_i.front) begin
      we = elem_vld && q_e && rdata_q.lv == 2'd0;
      wdata.pos = rdata_q.pos + 1'b1;
    end else if (cmd_i.boost) begin
      we         = elem_vld && used_e;
      wdata.lv   = 2'd0;
      wdata.prio = TOP_PRIO;
      wdata.rt   = '0;
      if (q_e) wdata.pos = IW'(CW'(rdata_q.pos) + boost_off);
    end else if (cmd_i.apply) begin
      waddr = target_q;
      wdata = ent_q;
      case (act)
        ACT_ADMIT: begin
          we    = 1'b1;
          wdata = '{lv: 2'd0, prio: TOP_PRIO, rt: '0, pid: req_q.task_id, pos: IW'(cnt0_q)};
        end
        ACT_YIELD: begin
          we = 1'b1;
          if (lock_q) begin
            wdata.rt = rt1;
          end else begin
            wdata.lv   = y_lv;
            wdata.rt   = y_rt;
            wdata.prio = y_prio;
            wdata.pos  = IW'(y_cnt);
          end
        end
        ACT_UNLOCK: begin
          we         = 1'b1;
          wdata.lv   = 2'd0;
          wdata.prio = TOP_PRIO;
          wdata.rt   = '0;
          wdata.pos  = '0;
        end
        ACT_SET_PRIO: begin
          we         = 1'b1;
          wdata.prio = req_q.new_priority;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  // Result of a successful transaction
  logic lock_nx;

  always_comb begin
    lock_nx = lock_q;
    case (act)
      ACT_LOCK:   lock_nx = 1'b1;
      ACT_UNLOCK: lock_nx = 1'b0;
      ACT_REMOVE: if (lock_q && holder_q == target_q) lock_nx = 1'b0;
      default:    lock_nx = lock_q;
    endcase
    res_d.granted      = (act == ACT_PICK);
    res_d.chosen_slot  = 6'(target_q);
    res_d.chosen_level = ent_q.lv;
    res_d.status       = STAT_OK;
    res_d.locked       = lock_nx;
    case (act)
      ACT_ADMIT, ACT_UNLOCK: res_d.chosen_level = 2'd0;
      ACT_YIELD: res_d.chosen_level = lock_q ? ent_q.lv : y_lv;
      ACT_BOOST: begin
        res_d.chosen_slot  = '0;
        res_d.chosen_level = 2'd0;
      end
      default: res_d.chosen_level = ent_q.lv;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= in_data_i;
    if (cmd_i.look_cap) ent_q <= rdata_q;
    if (cmd_i.decode) begin
      case (act)
        ACT_PICK, ACT_UNLOCK: target_q <= holder_q;
        ACT_YIELD, ACT_LOCK:  target_q <= run_q;
        default:              target_q <= slot_idx;
      endcase
      find_lv_q <= (cnt0_q != '0) ? 2'd0 : (cnt1_q != '0) ? 2'd1 : 2'd2;
      res_q     <= '{granted: 1'b0, chosen_slot: '0, chosen_level: '0,
                     status: err_code, locked: lock_q};
    end
    if (take) begin
      best_q      <= e;
      best_prio_q <= rdata_q.prio;
      best_pid_q  <= rdata_q.pid;
      best_pos_q  <= rdata_q.pos;
    end
    // The last slot is judged in the same cycle the sweep ends
    if (cmd_i.find && done) target_q <= take ? e : best_q;
    if (cmd_i.apply) res_q <= res_d;
    if (cmd_i.push) out_q <= res_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q   <= '0;
      cnt0_q     <= '0;
      cnt1_q     <= '0;
      cnt2_q     <= '0;
      run_vld_q  <= 1'b0;
      run_q      <= '0;
      lock_q     <= 1'b0;
      holder_q   <= '0;
      best_vld_q <= 1'b0;
      scan_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      scan_q    <= (scan && !done) ? scan_q + 1'b1 : '0;
      out_vld_q <= cmd_i.push || (out_vld_q && !out_ready_i);
      if (cmd_i.decode) best_vld_q <= 1'b0;
      if (take) best_vld_q <= 1'b1;
      // Drop the target from its level once the sweep has closed the gap
      if (cmd_i.unlink && done) begin
        queued_q[target_q] <= 1'b0;
        case (ent_q.lv)
          2'd0:    cnt0_q <= cnt0_q - 1'b1;
          2'd1:    cnt1_q <= cnt1_q - 1'b1;
          default: cnt2_q <= cnt2_q - 1'b1;
        endcase
      end
      if (cmd_i.boost && done) begin
        cnt0_q <= CW'(cnt0_q + cnt1_q + cnt2_q);
        cnt1_q <= '0;
        cnt2_q <= '0;
      end
      if (cmd_i.apply) begin
        case (act)
          ACT_ADMIT: begin
            queued_q[target_q] <= 1'b1;
            cnt0_q <= cnt0_q + 1'b1;
          end
          ACT_REMOVE: begin
            if (run_vld_q && run_q == target_q) run_vld_q <= 1'b0;
            if (lock_q && holder_q == target_q) begin
              lock_q   <= 1'b0;
              holder_q <= '0;
            end
          end
          ACT_PICK: begin
            run_vld_q <= 1'b1;
            run_q     <= target_q;
          end
          ACT_YIELD: begin
            run_vld_q <= 1'b0;
            if (!lock_q) begin
              queued_q[target_q] <= 1'b1;
              case (y_lv)
                2'd0:    cnt0_q <= cnt0_q + 1'b1;
                2'd1:    cnt1_q <= cnt1_q + 1'b1;
                default: cnt2_q <= cnt2_q + 1'b1;
              endcase
            end
          end
          ACT_LOCK: begin
            lock_q   <= 1'b1;
            holder_q <= run_q;
          end
          ACT_UNLOCK: begin
            lock_q   <= 1'b0;
            holder_q <= '0;
            if (run_vld_q && run_q == target_q) run_vld_q <= 1'b0;
            queued_q[target_q] <= 1'b1;
            cnt0_q <= cnt0_q + 1'b1;
          end
          default: lock_q <= lock_q;
        endcase
      end
    end
  end

  assign stat_o.act        = act;
  assign stat_o.err        = err_code != STAT_OK;
  assign stat_o.locked     = lock_q;
  assign stat_o.tgt_queued = queued_q[target_q];
  assign stat_o.scan_done  = done;
  assign stat_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hw/rtl/three_level_feedback_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler
// Three-level feedback queue scheduler with an APB lock-key register.
// ----------------------------------------------------------------------------
// The block takes one scheduling transaction at a time and returns exactly
// one result transaction for each. Task state lives in a single-port-read,
// single-port-write table of TaskSlots entries; each queued task carries its
// place within its level, so moving tasks within a level works as a sweep
// over the table at one slot per cycle. A failing request, admit, lock,
// tick-yield, set-priority, a pick while locked and remove of a task that is
// not queued need no sweep; a pick from any level costs one find sweep plus
// one unlink sweep; remove of a queued task costs one unlink sweep, unlock a
// front sweep, after an unlink sweep if its task is queued, and boost one
// boost sweep. The sweeps over the task table set the cost of these
// transactions. No clearing pass is needed after reset: queue membership is
// kept in flip-flops. A finished result is held in an output register, so a
// new transaction can be accepted while the previous result still waits.
// The lock key register sits at address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_feedback_queue_scheduler import tlfq_pkg::*; #(
  parameter int unsigned TaskSlots = DEF_TASK_SLOTS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Scheduling requests
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sched_in_t         in_data_i,
  // Results
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sched_out_t             out_data_o,
  // Configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] lock_key_q;

  // Lock key register: write on the access phase, zero wait states
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LOCK_KEY) ? lock_key_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_key_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LOCK_KEY) begin
      lock_key_q <= pwdata;
    end
  end

  // Sequencer: decides which sweeps a transaction needs
  tlfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Task table, queue counts, running task and lock state
  tlfq_dp #(
    .TaskSlots (TaskSlots)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .lock_key_i  (lock_key_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // A failed request reports no slot and no level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_OK |->
      out_data_o.chosen_slot == '0 && out_data_o.chosen_level == '0)
    else $error("failed request carries a slot or level");

  // A grant only comes with success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.status == STAT_OK)
    else $error("grant with non-ok status");

  // One transaction at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");
`endif

endmodule

`default_nettype wire
